// ----- src/atdg_pkg.sv -----
// Shared types, widths and helper functions of the attention tile descriptor generator.
// Depends on nothing; every other file of the block imports it.
package atdg_pkg;

    localparam int TILE_ROWS  = 16;
    localparam int MAX_TILES  = 64;

    localparam int SEQ_W      = 11;
    localparam int ID_W       = 12;
    localparam int ROW_W      = 10;
    localparam int BASE_W     = 16;
    localparam int ACT_W      = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Tile indexes must be able to hold MAX_TILES itself.
    localparam int IDX_W      = $clog2(MAX_TILES + 1);

    // Row arithmetic is carried out wide enough for both tile rows and the sequence length.
    localparam int ROWX_W     = IDX_W + $clog2(TILE_ROWS) + 1;
    localparam int WIDE_W     = (ROWX_W > SEQ_W) ? ROWX_W : SEQ_W;

    // Ceiling division by TILE_ROWS as a multiplication by a rounded-up reciprocal.
    localparam int NUM_W      = SEQ_W + 1;
    localparam int DIV_SHIFT  = NUM_W + $clog2(TILE_ROWS);
    localparam int MUL_W      = DIV_SHIFT + 1;
    localparam int PROD_W     = NUM_W + MUL_W;
    localparam logic [MUL_W-1:0] DIV_MUL =
        MUL_W'(((2 ** DIV_SHIFT) + TILE_ROWS - 1) / TILE_ROWS);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SEQ_LENGTH,
        REG_CAUSAL_MODE,
        REG_Q_EVEN_BASE,
        REG_Q_ODD_BASE,
        REG_K_EVEN_BASE,
        REG_K_ODD_BASE,
        REG_V_EVEN_BASE,
        REG_V_ODD_BASE
    } t_cfg_reg;

    typedef enum logic [0:0] {
        KIND_QUERY = 1'b0,
        KIND_PAIR  = 1'b1
    } t_kind;

    typedef struct packed {
        logic [SEQ_W-1:0]  seq_length;
        logic [IDX_W-1:0]  tiles;
        logic              causal_mode;
        logic [BASE_W-1:0] q_even_base;
        logic [BASE_W-1:0] q_odd_base;
        logic [BASE_W-1:0] k_even_base;
        logic [BASE_W-1:0] k_odd_base;
        logic [BASE_W-1:0] v_even_base;
        logic [BASE_W-1:0] v_odd_base;
    } t_cfg;

    typedef struct packed {
        t_kind             kind;
        logic [ID_W-1:0]   desc_id;
        logic [ROW_W-1:0]  start_row;
        logic [BASE_W-1:0] first_base;
        logic [BASE_W-1:0] second_base;
        logic [ACT_W-1:0]  row_count;
        logic              run_last;
    } t_desc;

    // Number of tiles in a run, saturated at MAX_TILES.
    function automatic logic [IDX_W-1:0] tile_count(input logic [SEQ_W-1:0] seq);
        logic [NUM_W-1:0]  num;
        logic [PROD_W-1:0] prod;
        logic [NUM_W-1:0]  quot;
        num  = NUM_W'(seq) + NUM_W'(TILE_ROWS - 1);
        prod = PROD_W'(num) * PROD_W'(DIV_MUL);
        quot = NUM_W'(prod >> DIV_SHIFT);
        if (quot > NUM_W'(MAX_TILES)) begin
            return IDX_W'(MAX_TILES);
        end
        return IDX_W'(quot);
    endfunction

    function automatic logic [WIDE_W-1:0] tile_row(input logic [IDX_W-1:0] idx);
        return WIDE_W'(idx) * WIDE_W'(TILE_ROWS);
    endfunction

    // Rows left from the tile's first row to the end of the sequence, at most one tile.
    function automatic logic [ACT_W-1:0] rows_left(input logic [IDX_W-1:0] idx,
                                                   input logic [SEQ_W-1:0] seq);
        logic [WIDE_W-1:0] row;
        logic [WIDE_W-1:0] rem;
        row = tile_row(idx);
        rem = (row < WIDE_W'(seq)) ? (WIDE_W'(seq) - row) : '0;
        if (rem > WIDE_W'(TILE_ROWS)) begin
            rem = WIDE_W'(TILE_ROWS);
        end
        return ACT_W'(rem);
    endfunction

endpackage

// ----- src/atdg_cfg_regs.sv -----
// Configuration register file of the descriptor generator.
// Depends on atdg_pkg; the tile count is worked out as seq_length is written.
module atdg_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wen,
    input  logic [atdg_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [atdg_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output atdg_pkg::t_cfg                    o_cfg
);
    import atdg_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_wen) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_SEQ_LENGTH: begin
                    n_cfg.seq_length = i_cfg_data[SEQ_W-1:0];
                    n_cfg.tiles      = tile_count(i_cfg_data[SEQ_W-1:0]);
                end
                REG_CAUSAL_MODE: n_cfg.causal_mode = i_cfg_data[0];
                REG_Q_EVEN_BASE: n_cfg.q_even_base = i_cfg_data[BASE_W-1:0];
                REG_Q_ODD_BASE:  n_cfg.q_odd_base  = i_cfg_data[BASE_W-1:0];
                REG_K_EVEN_BASE: n_cfg.k_even_base = i_cfg_data[BASE_W-1:0];
                REG_K_ODD_BASE:  n_cfg.k_odd_base  = i_cfg_data[BASE_W-1:0];
                REG_V_EVEN_BASE: n_cfg.v_even_base = i_cfg_data[BASE_W-1:0];
                REG_V_ODD_BASE:  n_cfg.v_odd_base  = i_cfg_data[BASE_W-1:0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- src/atdg_sequencer.sv -----
// Run state of the descriptor generator and the descriptor built from it.
// Depends on atdg_pkg; the state advances once per accepted request.
module atdg_sequencer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_advance,
    input  logic             i_restart,
    input  atdg_pkg::t_cfg   i_cfg,
    output logic             o_emit,
    output atdg_pkg::t_desc  o_desc
);
    import atdg_pkg::*;

    logic [IDX_W-1:0] r_query_idx, n_query_idx;
    logic [IDX_W-1:0] r_key_idx,   n_key_idx;
    logic [IDX_W-1:0] r_key_limit, n_key_limit;
    logic [ID_W-1:0]  r_pair_id,   n_pair_id;
    logic             r_emit_query, n_emit_query;
    logic             r_run_active, n_run_active;

    logic [IDX_W-1:0] s_query_idx, s_key_idx, s_key_limit;
    logic [ID_W-1:0]  s_pair_id;
    logic             s_emit_query, s_run_active;
    logic [IDX_W-1:0] s_key_inc, s_query_inc;
    logic [IDX_W-1:0] s_tile_idx;
    logic             s_emit;
    t_desc            s_desc;

    always_comb begin
        // A restart clears the run before this request is served.
        if (i_restart) begin
            s_query_idx  = '0;
            s_key_idx    = '0;
            s_key_limit  = '0;
            s_pair_id    = '0;
            s_emit_query = 1'b1;
            s_run_active = (i_cfg.tiles != '0);
        end else begin
            s_query_idx  = r_query_idx;
            s_key_idx    = r_key_idx;
            s_key_limit  = r_key_limit;
            s_pair_id    = r_pair_id;
            s_emit_query = r_emit_query;
            s_run_active = r_run_active;
        end

        s_key_inc   = s_key_idx + IDX_W'(1);
        s_query_inc = s_query_idx + IDX_W'(1);
        s_tile_idx  = s_emit_query ? s_query_idx : s_key_idx;

        n_query_idx  = s_query_idx;
        n_key_idx    = s_key_idx;
        n_key_limit  = s_key_limit;
        n_pair_id    = s_pair_id;
        n_emit_query = s_emit_query;
        n_run_active = s_run_active;
        s_emit       = 1'b0;

        s_desc.start_row = ROW_W'(tile_row(s_tile_idx));
        s_desc.row_count = rows_left(s_tile_idx, i_cfg.seq_length);
        s_desc.run_last  = 1'b0;
        if (s_emit_query) begin
            s_desc.kind        = KIND_QUERY;
            s_desc.desc_id     = ID_W'(s_query_idx);
            s_desc.first_base  = s_query_idx[0] ? i_cfg.q_odd_base : i_cfg.q_even_base;
            s_desc.second_base = '0;
        end else begin
            s_desc.kind        = KIND_PAIR;
            s_desc.desc_id     = s_pair_id;
            s_desc.first_base  = s_key_idx[0] ? i_cfg.k_odd_base : i_cfg.k_even_base;
            s_desc.second_base = s_key_idx[0] ? i_cfg.v_odd_base : i_cfg.v_even_base;
        end

        if (s_run_active) begin
            if (s_emit_query) begin
                if (s_query_idx >= i_cfg.tiles) begin
                    n_run_active = 1'b0;
                end else begin
                    s_emit       = 1'b1;
                    n_key_limit  = i_cfg.causal_mode ? s_query_inc : i_cfg.tiles;
                    n_key_idx    = '0;
                    n_emit_query = 1'b0;
                end
            end else begin
                s_emit    = 1'b1;
                n_pair_id = s_pair_id + ID_W'(1);
                if (s_key_inc >= s_key_limit) begin
                    n_query_idx  = s_query_inc;
                    n_key_idx    = '0;
                    n_emit_query = 1'b1;
                    if (s_query_inc >= i_cfg.tiles) begin
                        n_run_active    = 1'b0;
                        s_desc.run_last = 1'b1;
                    end
                end else begin
                    n_key_idx = s_key_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_query_idx  <= '0;
            r_key_idx    <= '0;
            r_key_limit  <= '0;
            r_pair_id    <= '0;
            r_emit_query <= 1'b1;
            r_run_active <= 1'b0;
        end else if (i_advance) begin
            r_query_idx  <= n_query_idx;
            r_key_idx    <= n_key_idx;
            r_key_limit  <= n_key_limit;
            r_pair_id    <= n_pair_id;
            r_emit_query <= n_emit_query;
            r_run_active <= n_run_active;
        end
    end

    assign o_emit = s_emit;
    assign o_desc = s_desc;

endmodule

// ----- src/atdg_out_stage.sv -----
// Output register with a skid slot for the descriptor channel.
// Depends on atdg_pkg for the descriptor type.
module atdg_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  atdg_pkg::t_desc  i_desc,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_stall,
    output atdg_pkg::t_desc  o_desc
);
    import atdg_pkg::*;

    logic  r_out_valid, n_out_valid;
    logic  r_skid_valid, n_skid_valid;
    t_desc r_out, n_out;
    t_desc r_skid, n_skid;
    logic  s_take;

    assign s_take = r_out_valid && !i_stall;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (r_skid_valid) begin
            // No push can arrive while the skid slot is occupied.
            if (s_take) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_valid || s_take) begin
                n_out       = i_desc;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = i_desc;
                n_skid_valid = 1'b1;
            end
        end else if (s_take) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_desc  = r_out;

endmodule

// ----- src/attention_tile_descriptor_generator.sv -----
// Top level of the attention tile descriptor generator.
// Depends on atdg_pkg, atdg_cfg_regs, atdg_sequencer and atdg_out_stage.

// Every accepted request is served at its accepting edge: the run state advances there and
// the descriptor it yields, if any, lands in the output register or the skid slot, so one
// request and one descriptor per cycle are sustained while o_stall is low, as the tile
// counters update at each accepted request. A two-entry output stage (register plus skid
// slot) lets requests keep coming while a descriptor waits; the request side stalls only
// when both entries are full. Requests that yield nothing (an idle advance, an empty run)
// produce no output. The tile count is derived at the moment seq_length is written, so a
// request may follow a configuration write in the very next cycle.
module attention_tile_descriptor_generator (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic                             i_restart,
    input  logic                             i_cfg_wen,
    input  logic [atdg_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [atdg_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic                             o_kind,
    output logic [atdg_pkg::ID_W-1:0]        o_desc_id,
    output logic [atdg_pkg::ROW_W-1:0]       o_start_row,
    output logic [atdg_pkg::BASE_W-1:0]      o_first_base,
    output logic [atdg_pkg::BASE_W-1:0]      o_second_base,
    output logic [atdg_pkg::ACT_W-1:0]       o_row_count,
    output logic                             o_run_last
);
    import atdg_pkg::*;

    t_cfg  s_cfg;
    t_desc s_seq_desc;
    t_desc s_out_desc;
    logic  s_emit;
    logic  s_full;
    logic  s_accept;

    assign o_stall  = s_full;
    assign s_accept = i_valid && !s_full;

    atdg_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (s_cfg)
    );

    atdg_sequencer u_sequencer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (s_accept),
        .i_restart (i_restart),
        .i_cfg     (s_cfg),
        .o_emit    (s_emit),
        .o_desc    (s_seq_desc)
    );

    atdg_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_accept && s_emit),
        .i_desc  (s_seq_desc),
        .o_full  (s_full),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_desc  (s_out_desc)
    );

    assign o_kind        = s_out_desc.kind;
    assign o_desc_id     = s_out_desc.desc_id;
    assign o_start_row   = s_out_desc.start_row;
    assign o_first_base  = s_out_desc.first_base;
    assign o_second_base = s_out_desc.second_base;
    assign o_row_count   = s_out_desc.row_count;
    assign o_run_last    = s_out_desc.run_last;

endmodule
